/* sv/ttwm_pkg.sv */
// ============================================================================
// ttwm_pkg
// Shared codes, reset constants and the evaluation result type of the
// thermal trip window monitor.
// ============================================================================
package ttwm_pkg;

    // Command codes
    localparam logic [2:0] CMD_SAMPLE    = 3'd0;
    localparam logic [2:0] CMD_SET_TEMP  = 3'd1;
    localparam logic [2:0] CMD_SET_HYST  = 3'd2;
    localparam logic [2:0] CMD_READ_TRIP = 3'd3;
    localparam logic [2:0] CMD_READ_ZONE = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZONE_ERR = 2'd1;
    localparam logic [1:0] STATUS_TRIP_ERR = 2'd2;

    // Reset values
    localparam logic signed [31:0] TRIP_TEMP_RESET = 32'sd125000;
    localparam logic signed [31:0] TRIP_HYST_RESET = 32'sd1000;
    localparam logic [30:0]        THRESH_RESET    = 31'd1000;
    localparam logic signed [31:0] WIN_NONE_LOW    = -32'sd2147483647;
    localparam logic signed [31:0] WIN_NONE_HIGH   = 32'sd2147483647;

    typedef struct packed {
        logic [1:0]         status;
        logic               trigger;
        logic signed [31:0] window_low;
        logic signed [31:0] window_high;
        logic signed [31:0] trip_temp;
        logic signed [31:0] trip_hyst;
        logic               trip_we;
        logic               win_we;
    } eval_t;

endpackage

/* sv/ttwm_if.sv */
// ============================================================================
// ttwm_if
// Request and result channels of the thermal trip window monitor.
// ============================================================================
interface ttwm_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [1:0]         zone;
    logic [1:0]         trip_index;
    logic signed [31:0] value;

    modport source (output valid, cmd, zone, trip_index, value, input ready);
    modport sink   (input valid, cmd, zone, trip_index, value, output ready);
endinterface

interface ttwm_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               trigger;
    logic signed [31:0] window_low;
    logic signed [31:0] window_high;
    logic signed [31:0] trip_temp_out;
    logic signed [31:0] trip_hyst_out;
    logic signed [31:0] zone_temp_out;
    logic [30:0]        max_temp;

    modport source (output valid, status, trigger, window_low, window_high,
                    trip_temp_out, trip_hyst_out, zone_temp_out, max_temp,
                    input ready);
    modport sink   (input valid, status, trigger, window_low, window_high,
                    trip_temp_out, trip_hyst_out, zone_temp_out, max_temp,
                    output ready);
endinterface

/* sv/ttwm_row_mem.sv */
// ============================================================================
// ttwm_row_mem
// Row memory with registered read, per-row valid bits that stand
// in for the reset contents, and write-to-read forwarding.
// ============================================================================
module ttwm_row_mem #(
    parameter int               DEPTH     = 3,
    parameter int               WIDTH     = 64,
    parameter logic [WIDTH-1:0] RESET_ROW = '0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [WIDTH-1:0] rd_q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             rd_valid_reg;
    logic             fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
                // take the row being written at the same edge
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? rd_q_reg     : RESET_ROW;

endmodule

/* sv/ttwm_eval.sv */
// ============================================================================
// ttwm_eval
// Command evaluation: window rebuild, trigger test and trip row update.
// ============================================================================
module ttwm_eval #(
    parameter int TRIPS_PER_ZONE = 2
) (
    input  logic [2:0]                     cmd,
    input  logic                           zone_ok,
    input  logic                           trip_ok,
    input  logic [((TRIPS_PER_ZONE > 1) ? $clog2(TRIPS_PER_ZONE) : 1)-1:0] trip_sel,
    input  logic signed [31:0]             value,
    input  logic [TRIPS_PER_ZONE*64-1:0]   trip_row,
    input  logic [63:0]                    win_row,
    input  logic signed [31:0]             zone_temp,
    input  logic [30:0]                    threshold,
    output logic [TRIPS_PER_ZONE*64-1:0]   trip_row_new,
    output logic [63:0]                    win_row_new,
    output ttwm_pkg::eval_t                ev
);

    logic signed [31:0] temps      [TRIPS_PER_ZONE];
    logic signed [31:0] hysts      [TRIPS_PER_ZONE];
    logic signed [31:0] temps_new  [TRIPS_PER_ZONE];
    logic signed [31:0] hysts_new  [TRIPS_PER_ZONE];
    logic signed [32:0] trip_floor [TRIPS_PER_ZONE];
    logic signed [32:0] low_acc;
    logic signed [31:0] high_acc;
    logic signed [32:0] sample_x;
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic signed [31:0] win_low;
    logic signed [31:0] win_high;
    logic signed [31:0] low_new;
    logic signed [31:0] high_new;

    assign win_low  = win_row[31:0];
    assign win_high = win_row[63:32];
    assign sample_x = {value[31], value};

    // Window rebuild over the zone's trip points
    always_comb
    begin
        low_acc  = {ttwm_pkg::WIN_NONE_LOW[31], ttwm_pkg::WIN_NONE_LOW};
        high_acc = ttwm_pkg::WIN_NONE_HIGH;
        for (int t = 0; t < TRIPS_PER_ZONE; t++)
        begin
            temps[t]      = trip_row[t*32 +: 32];
            hysts[t]      = trip_row[(TRIPS_PER_ZONE + t)*32 +: 32];
            trip_floor[t] = {temps[t][31], temps[t]} - {hysts[t][31], hysts[t]};
            if ((trip_floor[t] < sample_x) && (trip_floor[t] > low_acc))
            begin
                low_acc = trip_floor[t];
            end
            if ((temps[t] > value) && (temps[t] < high_acc))
            begin
                high_acc = temps[t];
            end
        end
    end

    assign diff     = {zone_temp[31], zone_temp} - sample_x;
    assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);

    always_comb
    begin
        temps_new  = temps;
        hysts_new  = hysts;
        low_new    = win_low;
        high_new   = win_high;
        ev         = '0;
        ev.status  = ttwm_pkg::STATUS_OK;
        if (!zone_ok)
        begin
            ev.status = ttwm_pkg::STATUS_ZONE_ERR;
        end
        else
        begin
            unique case (cmd) inside
                ttwm_pkg::CMD_SAMPLE:
                begin
                    ev.win_we  = 1'b1;
                    low_new    = low_acc[31:0];
                    high_new   = high_acc;
                    ev.trigger = (value >= win_high) || (value <= win_low) ||
                                 (abs_diff >= {2'b00, threshold});
                end
                ttwm_pkg::CMD_SET_TEMP, ttwm_pkg::CMD_SET_HYST, ttwm_pkg::CMD_READ_TRIP:
                begin
                    if (!trip_ok)
                    begin
                        ev.status = ttwm_pkg::STATUS_TRIP_ERR;
                    end
                    else if (cmd == ttwm_pkg::CMD_SET_TEMP)
                    begin
                        temps_new[trip_sel] = value;
                        ev.trip_we          = 1'b1;
                    end
                    else if (cmd == ttwm_pkg::CMD_SET_HYST)
                    begin
                        hysts_new[trip_sel] = value;
                        ev.trip_we          = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            ev.window_low  = low_new;
            ev.window_high = high_new;
            if (trip_ok)
            begin
                ev.trip_temp = temps_new[trip_sel];
                ev.trip_hyst = hysts_new[trip_sel];
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < TRIPS_PER_ZONE; t++)
        begin
            trip_row_new[t*32 +: 32]                    = temps_new[t];
            trip_row_new[(TRIPS_PER_ZONE + t)*32 +: 32] = hysts_new[t];
        end
    end

    assign win_row_new = {high_new, low_new};

endmodule

/* sv/thermal_trip_window_monitor_top.sv */
// ============================================================================
// thermal_trip_window_monitor_top
// Per-zone trip window tracking with hysteresis and change trigger.
// ============================================================================
// Usage:
//   request carries one command per request (sample, set trip temperature,
//   set trip hysteresis, read trip, read zone). result returns exactly one
//   item per request, in order, with status, trigger, the zone's window,
//   the addressed trip point, the zone temperature and the zone maximum.
//   cfg_we/cfg_wdata write the change threshold; write it only while idle.
// Pipeline and throughput:
//   A request is taken at an edge with valid and ready high; the trip and
//   window memories are read at that edge, the output register loads when
//   evaluation fires. One request per cycle is sustained while result is
//   taken; the memories are written as the request leaves evaluation, and a
//   request that reads the row written at its own accept edge is forwarded.
// Reset:
//   Valid bits make all trip rows read as 125000/1000 and all windows as the
//   open sentinels at once; zone temperatures clear to zero, threshold 1000.
//   There is no clearing pass.
// Stall:
//   When result is not taken, the output register holds, the evaluation
//   stage holds its request, and request.ready drops until space opens.
// ============================================================================
module thermal_trip_window_monitor_top #(
    parameter int NUM_ZONES      = 3,
    parameter int TRIPS_PER_ZONE = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    ttwm_req_if.sink    request,
    ttwm_res_if.source  result
);

    localparam int ZW      = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int ZXW     = ((ZW > 2) ? ZW : 2) + 1;
    localparam int TW      = (TRIPS_PER_ZONE > 1) ? $clog2(TRIPS_PER_ZONE) : 1;
    localparam int TXW     = ((TW > 2) ? TW : 2) + 1;
    localparam int TRIP_RW = TRIPS_PER_ZONE * 64;

    localparam logic [TRIP_RW-1:0] TRIP_RESET_ROW =
        {{TRIPS_PER_ZONE{ttwm_pkg::TRIP_HYST_RESET}},
         {TRIPS_PER_ZONE{ttwm_pkg::TRIP_TEMP_RESET}}};
    localparam logic [63:0] WIN_RESET_ROW =
        {ttwm_pkg::WIN_NONE_HIGH, ttwm_pkg::WIN_NONE_LOW};

    // Accept-side decode
    logic [ZXW-1:0] zone_ext;
    logic [TXW-1:0] trip_ext;
    logic           zone_ok;
    logic           trip_ok;
    logic           accept;

    // Evaluation stage
    logic               s1_valid_reg;
    logic [2:0]         s1_cmd_reg;
    logic [ZW-1:0]      s1_zone_reg;
    logic               s1_zone_ok_reg;
    logic [TW-1:0]      s1_trip_sel_reg;
    logic               s1_trip_ok_reg;
    logic signed [31:0] s1_value_reg;
    logic               s1_fire;

    logic [30:0]        thresh_reg;
    logic signed [31:0] zone_temp_reg  [NUM_ZONES];
    logic signed [31:0] zone_temp_next [NUM_ZONES];
    logic signed [31:0] zone_temp_cur;
    logic               zone_we;
    logic signed [31:0] max_acc;

    logic [TRIP_RW-1:0] trip_row;
    logic [TRIP_RW-1:0] trip_row_new;
    logic [63:0]        win_row;
    logic [63:0]        win_row_new;
    ttwm_pkg::eval_t    ev;

    // Output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         out_status_reg;
    logic               out_trigger_reg;
    logic signed [31:0] out_low_reg;
    logic signed [31:0] out_high_reg;
    logic signed [31:0] out_trip_temp_reg;
    logic signed [31:0] out_trip_hyst_reg;
    logic signed [31:0] out_zone_temp_reg;
    logic [30:0]        out_max_reg;

    assign zone_ext = ZXW'(request.zone);
    assign trip_ext = TXW'(request.trip_index);
    assign zone_ok  = zone_ext < ZXW'(NUM_ZONES);
    assign trip_ok  = trip_ext < TXW'(TRIPS_PER_ZONE);

    // Advance the evaluation stage when the output register is free or drains
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !s1_valid_reg || s1_fire;
    assign accept        = request.valid && request.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= request.cmd;
            s1_zone_reg     <= zone_ext[ZW-1:0];
            s1_zone_ok_reg  <= zone_ok;
            s1_trip_sel_reg <= trip_ext[TW-1:0];
            s1_trip_ok_reg  <= trip_ok;
            s1_value_reg    <= request.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= ttwm_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    // Trip table: one row per zone, all trip points of the zone side by side
    ttwm_row_mem #(
        .DEPTH     (NUM_ZONES),
        .WIDTH     (TRIP_RW),
        .RESET_ROW (TRIP_RESET_ROW)
    ) u_trip_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && zone_ok),
        .rd_addr (zone_ext[ZW-1:0]),
        .wr_en   (s1_fire && ev.trip_we),
        .wr_addr (s1_zone_reg),
        .wr_data (trip_row_new),
        .rd_data (trip_row)
    );

    // Window table: {high, low} per zone
    ttwm_row_mem #(
        .DEPTH     (NUM_ZONES),
        .WIDTH     (64),
        .RESET_ROW (WIN_RESET_ROW)
    ) u_win_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && zone_ok),
        .rd_addr (zone_ext[ZW-1:0]),
        .wr_en   (s1_fire && ev.win_we),
        .wr_addr (s1_zone_reg),
        .wr_data (win_row_new),
        .rd_data (win_row)
    );

    assign zone_temp_cur = zone_temp_reg[s1_zone_reg];

    ttwm_eval #(
        .TRIPS_PER_ZONE (TRIPS_PER_ZONE)
    ) u_eval (
        .cmd          (s1_cmd_reg),
        .zone_ok      (s1_zone_ok_reg),
        .trip_ok      (s1_trip_ok_reg),
        .trip_sel     (s1_trip_sel_reg),
        .value        (s1_value_reg),
        .trip_row     (trip_row),
        .win_row      (win_row),
        .zone_temp    (zone_temp_cur),
        .threshold    (thresh_reg),
        .trip_row_new (trip_row_new),
        .win_row_new  (win_row_new),
        .ev           (ev)
    );

    // Zone temperatures stay in flops so the maximum sees all of them
    assign zone_we = s1_fire && s1_zone_ok_reg && (s1_cmd_reg == ttwm_pkg::CMD_SAMPLE);

    always_comb
    begin
        zone_temp_next = zone_temp_reg;
        if (zone_we)
        begin
            zone_temp_next[s1_zone_reg] = s1_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int z = 0; z < NUM_ZONES; z++)
            begin
                zone_temp_reg[z] <= '0;
            end
        end
        else
        begin
            zone_temp_reg <= zone_temp_next;
        end
    end

    // Maximum over the updated zone temperatures, floored at zero
    always_comb
    begin
        max_acc = '0;
        for (int z = 0; z < NUM_ZONES; z++)
        begin
            if (zone_temp_next[z] > max_acc)
            begin
                max_acc = zone_temp_next[z];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_status_reg    <= ev.status;
            out_trigger_reg   <= ev.trigger;
            out_low_reg       <= ev.window_low;
            out_high_reg      <= ev.window_high;
            out_trip_temp_reg <= ev.trip_temp;
            out_trip_hyst_reg <= ev.trip_hyst;
            out_zone_temp_reg <= s1_zone_ok_reg ? zone_temp_next[s1_zone_reg] : '0;
            out_max_reg       <= max_acc[30:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.trigger       = out_trigger_reg;
    assign result.window_low    = out_low_reg;
    assign result.window_high   = out_high_reg;
    assign result.trip_temp_out = out_trip_temp_reg;
    assign result.trip_hyst_out = out_trip_hyst_reg;
    assign result.zone_temp_out = out_zone_temp_reg;
    assign result.max_temp      = out_max_reg;

    // A request leaving evaluation always lands in the output register
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("evaluated request did not reach the output register");

    // An empty evaluation stage never back-pressures the request channel
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> request.ready)
        else $error("request stalled with empty evaluation stage");

    // Table writes only come from requests with a valid zone
    a_write_zone_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ev.trip_we || ev.win_we) |-> s1_zone_ok_reg)
        else $error("table write for out-of-range zone");

    // Rejected requests never raise the trigger
    a_no_trig_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ttwm_pkg::STATUS_OK)) |-> !out_trigger_reg)
        else $error("trigger set on rejected request");

endmodule
